/* rtl/iiel_pkg.sv */
// ----------------------------------------------------------------------------
// iiel_pkg
// Types and codes shared by the indexed insert/erase list and its channels.
// ----------------------------------------------------------------------------
package iiel_pkg;

  typedef logic        [1:0]  op_t;
  typedef logic        [4:0]  idx_t;
  typedef logic signed [31:0] word_t;
  typedef logic        [1:0]  status_t;
  typedef logic        [4:0]  count_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_ERASE  = 2'd1;
  localparam op_t OP_READ   = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // per-cell shift control, decoded once at the top
  typedef struct packed {
    logic ins;   // insert moves this cycle
    logic ers;   // erase moves this cycle
    logic at;    // cell sits at the target index
    logic past;  // cell sits above the target index
  } cell_ctrl_t;

endpackage

/* rtl/iiel_in_if.sv */
// ----------------------------------------------------------------------------
// iiel_in_if
// Request channel of the list: operation, index and value with valid/ready.
// ----------------------------------------------------------------------------
interface iiel_in_if;
  logic             valid;
  logic             ready;
  iiel_pkg::op_t    op;
  iiel_pkg::idx_t   index;
  iiel_pkg::word_t  value;

  modport source (output valid, output op, output index, output value, input ready);
  modport sink   (input valid, input op, input index, input value, output ready);
endinterface

/* rtl/iiel_out_if.sv */
// ----------------------------------------------------------------------------
// iiel_out_if
// Response channel of the list: status, read word and count with valid/ready.
// ----------------------------------------------------------------------------
interface iiel_out_if;
  logic               valid;
  logic               ready;
  iiel_pkg::status_t  status;
  iiel_pkg::word_t    read_value;
  iiel_pkg::count_t   count;

  modport source (output valid, output status, output read_value, output count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input count,
                  output ready);
endinterface

/* rtl/iiel_cell.sv */
// ----------------------------------------------------------------------------
// iiel_cell
// One list slot: holds a word and loads it from its neighbor or the new value.
// ----------------------------------------------------------------------------
module iiel_cell (
  input  logic                 clk_i,
  input  iiel_pkg::cell_ctrl_t ctrl_i,
  input  iiel_pkg::word_t      value_i,
  input  iiel_pkg::word_t      left_i,
  input  iiel_pkg::word_t      right_i,
  output iiel_pkg::word_t      entry_o
);
  import iiel_pkg::*;

  word_t entry_q;
  word_t entry_d;
  logic  load;

  always_comb begin
    load    = 1'b0;
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (ctrl_i.past) begin
        load    = 1'b1;
        entry_d = left_i;
      end else if (ctrl_i.at) begin
        load    = 1'b1;
        entry_d = value_i;
      end
    end else if (ctrl_i.ers) begin
      if (ctrl_i.at || ctrl_i.past) begin
        load    = 1'b1;
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

/* rtl/indexed_insert_erase_list_unit.sv */
// ----------------------------------------------------------------------------
// indexed_insert_erase_list_unit
// Ordered list of up to DEPTH signed words kept in a row of slot cells.
// ----------------------------------------------------------------------------
//   channel  dir  payload                       word accepted when
//   req_i    in   op, index, value              valid && ready
//   rsp_o    out  status, read_value, count     valid && ready
//
// one request per cycle while req_i.ready is high; every slot shifts in the
// same cycle as the request is taken, and its response is registered in the
// response buffer; this two-word buffer takes one more request while the
// response side stalls; req_i.ready drops once both words are held
// reset clears the count and the response buffer; slot contents stay
// undefined until written
// ----------------------------------------------------------------------------
module indexed_insert_erase_list_unit #(
  parameter int DEPTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  iiel_in_if.sink    req_i,
  iiel_out_if.source rsp_o
);
  import iiel_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;
  localparam int RDN  = (DEPTH < 32) ? DEPTH : 32;
  localparam int RIW  = $clog2(RDN);

  logic [CW-1:0]   count_q, count_d;
  logic [CMPW-1:0] idx_w, cnt_w;
  word_t           entry [DEPTH];
  word_t           rd_arr [RDN];
  cell_ctrl_t      ctrl [DEPTH];

  status_t status;
  word_t   rd_word;
  logic    do_ins, do_ers, push, pop;

  // response buffer: head drives the port, tail catches a stalled word
  logic    head_vld_q, tail_vld_q;
  status_t head_st_q, tail_st_q;
  word_t   head_rd_q, tail_rd_q;
  count_t  head_cnt_q, tail_cnt_q;

  assign idx_w = CMPW'(req_i.index);
  assign cnt_w = CMPW'(count_q);

  always_comb begin
    status = ST_OK;
    do_ins = 1'b0;
    do_ers = 1'b0;
    case (req_i.op)
      OP_INSERT: begin
        if (idx_w > cnt_w) begin
          status = ST_RANGE;
        end else if (cnt_w >= CMPW'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_ERASE: begin
        if (idx_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          do_ers = 1'b1;
        end
      end
      OP_READ: begin
        if (idx_w >= cnt_w) begin
          status = ST_RANGE;
        end
      end
      default: status = ST_OK;
    endcase
  end

  assign req_i.ready = !tail_vld_q;
  assign push        = req_i.valid && req_i.ready;
  assign pop         = head_vld_q && rsp_o.ready;

  always_comb begin
    count_d = count_q;
    if (push && do_ins) begin
      count_d = count_q + CW'(1);
    end else if (push && do_ers) begin
      count_d = count_q - CW'(1);
    end
  end

  // only the first 32 slots are reachable by a 5-bit index
  for (genvar r = 0; r < RDN; r++) begin : g_rd
    assign rd_arr[r] = entry[r];
  end

  always_comb begin
    rd_word = '0;
    if (req_i.op == OP_READ && status == ST_OK) begin
      rd_word = rd_arr[req_i.index[RIW-1:0]];
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left, right;

    assign ctrl[i].ins  = push && do_ins;
    assign ctrl[i].ers  = push && do_ers;
    assign ctrl[i].at   = (idx_w == CMPW'(i));
    assign ctrl[i].past = (idx_w <  CMPW'(i));

    if (i == 0) begin : g_first
      assign left = req_i.value;
    end else begin : g_mid_l
      assign left = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = entry[i];
    end else begin : g_mid_r
      assign right = entry[i+1];
    end

    iiel_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .value_i (req_i.value),
      .left_i  (left),
      .right_i (right),
      .entry_o (entry[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (tail_vld_q) begin
        if (pop) begin
          tail_vld_q <= 1'b0;
        end
      end else if (push) begin
        if (head_vld_q && !pop) begin
          tail_vld_q <= 1'b1;
        end else begin
          head_vld_q <= 1'b1;
        end
      end else if (pop) begin
        head_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_vld_q) begin
      if (pop) begin
        head_st_q  <= tail_st_q;
        head_rd_q  <= tail_rd_q;
        head_cnt_q <= tail_cnt_q;
      end
    end else if (push) begin
      if (head_vld_q && !pop) begin
        tail_st_q  <= status;
        tail_rd_q  <= rd_word;
        tail_cnt_q <= count_t'(count_d);
      end else begin
        head_st_q  <= status;
        head_rd_q  <= rd_word;
        head_cnt_q <= count_t'(count_d);
      end
    end
  end

  assign rsp_o.valid      = head_vld_q;
  assign rsp_o.status     = head_st_q;
  assign rsp_o.read_value = head_rd_q;
  assign rsp_o.count      = head_cnt_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_w <= CMPW'(DEPTH))
    else $error("live count above capacity");

  a_tail_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_vld_q |-> head_vld_q)
    else $error("response tail held without head");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && do_ins) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the count");

  a_erase_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && do_ers) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("erase did not shrink the count");
`endif

endmodule

/* tb/indexed_insert_erase_list_unit_test.sv */
// ----------------------------------------------------------------------------
// indexed_insert_erase_list_unit_test
// Sends insert, erase and read requests to the list, first from a short table
// and then at random, while both channels stall at random. Every response is
// checked against a shadow copy of the list that is kept in step with the
// accepted requests.
// ----------------------------------------------------------------------------
module indexed_insert_erase_list_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import iiel_pkg::*;

  localparam int  DEPTH       = 16;
  localparam int  CLK_PERIOD  = 20;
  localparam int  STALL_LIMIT = 1000;
  localparam int  HOLD_CYCLES = 64;
  localparam int  PHASE_ITEMS = 630;
  localparam op_t OP_UNUSED   = 2'd3;

  typedef struct packed {
    status_t status;
    word_t   read_value;
    count_t  count;
  } reply_t;

  typedef struct {
    op_t    op;
    idx_t   index;
    word_t  value;
    bit     typed;   // reply below is taken as is
    reply_t reply;
  } row_t;

  bit clk_i  = 1'b0;
  bit rst_ni = 1'b0;

  iiel_in_if  req_if ();
  iiel_out_if rsp_if ();

  indexed_insert_erase_list_unit #(
    .DEPTH (DEPTH)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  word_t  shadow_slot [DEPTH];
  int     shadow_count;
  reply_t reply_q [$];
  int     src_idle_pct;
  int     snk_idle_pct;
  bit     hold_req;
  int     error_cnt;
  int     stall_cycles;
  int     n_insert, n_erase, n_read, n_unused, n_full, n_range, peak_count;

  function automatic reply_t apply_list_op(op_t op, idx_t index, word_t value);
    reply_t r;
    int     k;
    r = '0;
    case (op)
      OP_INSERT: begin
        n_insert++;
        if (index > shadow_count) begin
          r.status = ST_RANGE;
        end else if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (k = shadow_count; k > index; k--) shadow_slot[k] = shadow_slot[k - 1];
          shadow_slot[index] = value;
          shadow_count++;
        end
      end
      OP_ERASE: begin
        n_erase++;
        if (index >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          for (k = index; k + 1 < shadow_count; k++) shadow_slot[k] = shadow_slot[k + 1];
          shadow_count--;
        end
      end
      OP_READ: begin
        n_read++;
        if (index >= shadow_count || index >= DEPTH) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = shadow_slot[index];
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_RANGE) n_range++;
    if (shadow_count > peak_count) peak_count = shadow_count;
    r.count = count_t'(shadow_count);
    return r;
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(7))
      0:       return word_t'(32'h7fffffff);
      1:       return word_t'(32'h80000000);
      2:       return '0;
      3:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic row_t mk_row(op_t op, idx_t index, word_t value, bit typed,
                                  status_t st, word_t rd, count_t cnt);
    row_t row;
    row.op               = op;
    row.index            = index;
    row.value            = value;
    row.typed            = typed;
    row.reply.status     = st;
    row.reply.read_value = rd;
    row.reply.count      = cnt;
    return row;
  endfunction

  function automatic void note_error(string msg);
    if (error_cnt < 10) $display("ERROR at %0t: %s", $time, msg);
    error_cnt++;
  endfunction

  // one word on the request channel; the list is updated once it is taken
  task automatic offer(input op_t op, input idx_t index, input word_t value,
                       input bit typed, input reply_t typed_reply);
    reply_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.index <= index;
    req_if.value <= value;
    do @(posedge clk_i); while (!req_if.ready);
    r = apply_list_op(op, index, value);
    reply_q.push_back(typed ? typed_reply : r);
  endtask

  // sender goes quiet until every expected word is back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (reply_q.size() != 0);
  endtask

  // mostly well-aimed indices, a little noise over the whole field
  task automatic random_item(input int fill_pct);
    op_t   op;
    idx_t  index;
    word_t value;
    value = pick_word();
    if ($urandom_range(99) < 8) begin
      op    = op_t'($urandom_range(3));
      index = idx_t'($urandom_range(31));
    end else if ($urandom_range(99) < fill_pct) begin
      op    = OP_INSERT;
      index = idx_t'($urandom_range(shadow_count));
    end else begin
      op    = ($urandom_range(1) != 0) ? OP_ERASE : OP_READ;
      index = (shadow_count == 0) ? idx_t'($urandom_range(31))
                                  : idx_t'($urandom_range(shadow_count - 1));
    end
    offer(op, index, value, 1'b0, '0);
  endtask

  initial begin : rsp_sink
    int held;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // long hold-off so the request side backs up
        rsp_if.ready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : rsp_check
    reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (reply_q.size() == 0) begin
        note_error($sformatf("unexpected word: status %0d value %h count %0d",
                             rsp_if.status, rsp_if.read_value, rsp_if.count));
      end else begin
        want = reply_q.pop_front();
        if (rsp_if.status !== want.status || rsp_if.read_value !== want.read_value ||
            rsp_if.count !== want.count) begin
          note_error($sformatf({"expected status %0d value %h count %0d, ",
                                "got status %0d value %h count %0d"},
                               want.status, want.read_value, want.count,
                               rsp_if.status, rsp_if.read_value, rsp_if.count));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    row_t dir_rows [$];
    int   k, n, ph, fill_pct;
    req_if.valid = 1'b0;
    req_if.op    = OP_INSERT;
    req_if.index = '0;
    req_if.value = '0;
    shadow_count = 0;
    hold_req     = 1'b0;
    error_cnt    = 0;
    stall_cycles = 0;
    src_idle_pct = 24;
    snk_idle_pct = 59;

    // empty list, unused opcode, then the two extremes read back
    dir_rows.push_back(mk_row(OP_READ, 5'd0, '0, 1'b1, ST_RANGE, '0, 5'd0));
    dir_rows.push_back(mk_row(OP_ERASE, 5'd0, '0, 1'b1, ST_RANGE, '0, 5'd0));
    dir_rows.push_back(mk_row(OP_INSERT, 5'd1, '1, 1'b1, ST_RANGE, '0, 5'd0));
    dir_rows.push_back(mk_row(OP_UNUSED, 5'd31, '1, 1'b1, ST_OK, '0, 5'd0));
    dir_rows.push_back(mk_row(OP_INSERT, 5'd0, word_t'(32'h7fffffff), 1'b1,
                              ST_OK, '0, 5'd1));
    dir_rows.push_back(mk_row(OP_INSERT, 5'd0, word_t'(32'h80000000), 1'b1,
                              ST_OK, '0, 5'd2));
    dir_rows.push_back(mk_row(OP_READ, 5'd0, '0, 1'b1, ST_OK, word_t'(32'h80000000), 5'd2));
    dir_rows.push_back(mk_row(OP_READ, 5'd1, '0, 1'b1, ST_OK, word_t'(32'h7fffffff), 5'd2));
    // fill up at the front, the back and the middle
    for (k = 2; k < DEPTH; k++) begin
      dir_rows.push_back(mk_row(OP_INSERT, idx_t'((k % 3 == 0) ? 0 : (k % 3 == 1) ? k : k / 2),
                                pick_word(), 1'b0, ST_OK, '0, '0));
    end
    // full list: index is checked before capacity
    dir_rows.push_back(mk_row(OP_INSERT, 5'd16, '0, 1'b1, ST_FULL, '0, 5'd16));
    dir_rows.push_back(mk_row(OP_INSERT, 5'd17, '0, 1'b1, ST_RANGE, '0, 5'd16));
    dir_rows.push_back(mk_row(OP_READ, 5'd31, '0, 1'b1, ST_RANGE, '0, 5'd16));
    dir_rows.push_back(mk_row(OP_ERASE, 5'd16, '0, 1'b1, ST_RANGE, '0, 5'd16));
    dir_rows.push_back(mk_row(OP_READ, 5'd15, '0, 1'b0, ST_OK, '0, '0));
    dir_rows.push_back(mk_row(OP_ERASE, 5'd15, '0, 1'b0, ST_OK, '0, '0));
    dir_rows.push_back(mk_row(OP_ERASE, 5'd0, '0, 1'b0, ST_OK, '0, '0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].op, dir_rows[i].index, dir_rows[i].value,
            dir_rows[i].typed, dir_rows[i].reply);
    end

    for (ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 59 : 0;
      snk_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 24 : 0;
      wait_drained();
      fill_pct = 50;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // swing between growing, shrinking and balanced traffic
        if (n % 32 == 0) begin
          case ($urandom_range(2))
            0:       fill_pct = 85;
            1:       fill_pct = 15;
            default: fill_pct = 50;
          endcase
        end
        if (n == 100 && ph != 1) hold_req = 1'b1;
        if (n == 400) wait_drained();
        random_item(fill_pct);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("covered %0d requests: %0d inserts, %0d erases, %0d reads, %0d unused opcodes",
             n_insert + n_erase + n_read + n_unused, n_insert, n_erase, n_read, n_unused);
    $display("rejects: %0d full, %0d out of range; peak count %0d; %0d mismatches",
             n_full, n_range, peak_count, error_cnt);
    if (error_cnt == 0 && reply_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
